>>> hw/rtl/fcbs_pkg.sv
// Shared constants, types and helpers of the chained free block stack.
package fcbs_pkg;

   localparam int FREE_SLOTS = 50;
   localparam int BLOCK_BITS = 24;
   localparam int CFG_BITS = 24;
   localparam int IDX_BITS = $clog2(FREE_SLOTS);
   localparam int CNT_BITS = $clog2(FREE_SLOTS + 1);
   localparam int CMP_BITS = (BLOCK_BITS > CFG_BITS) ? BLOCK_BITS : CFG_BITS;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QFILL_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int OPC_BITS = 2;
   localparam int KIND_BITS = 3;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [OPC_BITS-1:0] OPC_ALLOC = 2'd0;
   localparam logic [OPC_BITS-1:0] OPC_FREE = 2'd1;
   localparam logic [OPC_BITS-1:0] OPC_REFILL = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_DATA_BLOCK = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEVICE_BLOCKS = 2'd1;

   localparam logic [CFG_BITS-1:0] FIRST_DATA_BLOCK_RESET = CFG_BITS'(2);
   localparam logic [CFG_BITS-1:0] DEVICE_BLOCKS_RESET = '1;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_ALLOC = 3'd0,
      KIND_NO_SPACE = 3'd1,
      KIND_READ_REQUEST = 3'd2,
      KIND_FREED = 3'd3,
      KIND_BAD_BLOCK = 3'd4,
      KIND_SPILL_WORD = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      CMD_ALLOC,
      CMD_FREE,
      CMD_REFILL
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_SPILL,
      ST_SPILL_PUSH,
      ST_SCAN,
      ST_BAD,
      ST_FINAL
   } state_type;

   typedef struct packed {
      cmd_type cmd;
      logic [BLOCK_BITS-1:0] block;
      logic read_error;
      logic in_range;
   } item_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] first_data_block;
      logic [CFG_BITS-1:0] device_blocks;
   } cfg_type;

   function automatic logic block_in_range(logic [BLOCK_BITS-1:0] b, cfg_type cfg);
      return (CMP_BITS'(b) >= CMP_BITS'(cfg.first_data_block)) &&
             (CMP_BITS'(b) < CMP_BITS'(cfg.device_blocks));
   endfunction

endpackage

>>> hw/rtl/fcbs_if.sv
// Request, result and register write channel interfaces.
interface fcbs_req_if import fcbs_pkg::*; ();
   logic valid;
   logic ready;
   logic [OPC_BITS-1:0] opcode;
   logic [BLOCK_BITS-1:0] block_number;
   logic read_error;
   modport source(output valid, opcode, block_number, read_error, input ready);
   modport sink(input valid, opcode, block_number, read_error, output ready);
endinterface

interface fcbs_rsp_if import fcbs_pkg::*; ();
   logic valid;
   logic ready;
   logic [KIND_BITS-1:0] kind;
   logic [BLOCK_BITS-1:0] block;
   logic last;
   logic [CNT_BITS-1:0] cached_count;
   logic [BLOCK_BITS-1:0] total_free;
   modport source(output valid, kind, block, last, cached_count, total_free, input ready);
   modport sink(input valid, kind, block, last, cached_count, total_free, output ready);
endinterface

interface fcbs_csr_if import fcbs_pkg::*; ();
   logic valid;
   logic ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CFG_BITS-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

>>> hw/rtl/fcbs_ram.sv
// Generic single write port RAM with one registered read port.
module fcbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/fcbs_front.sv
// Front part: accepts requests, classifies them and queues them for the back part.
module fcbs_front import fcbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   fcbs_req_if.sink    req_if,
   input  cfg_type     cfg,
   output logic        q_valid,
   output item_type    q_item,
   input  logic        q_pop
);

   item_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QFILL_BITS-1:0]  fill_ff, fill_in;
   logic                   accept;
   logic                   push;
   logic                   pop;
   item_type               new_item;

   assign req_if.ready = (fill_ff != QFILL_BITS'(QUEUE_DEPTH));
   assign accept = req_if.valid && req_if.ready;
   assign q_valid = (fill_ff != '0);
   assign q_item = entry_ff[rd_ptr_ff];
   assign pop = q_pop && q_valid;

   // Spare opcodes are taken and dropped here; they never reach the back part.
   always_comb begin
      new_item.block = req_if.block_number;
      new_item.read_error = req_if.read_error;
      new_item.in_range = block_in_range(req_if.block_number, cfg);
      new_item.cmd = CMD_ALLOC;
      push = 1'b0;
      unique case (req_if.opcode)
         OPC_ALLOC: begin
            new_item.cmd = CMD_ALLOC;
            push = accept;
         end
         OPC_FREE: begin
            new_item.cmd = CMD_FREE;
            push = accept;
         end
         OPC_REFILL: begin
            new_item.cmd = CMD_REFILL;
            push = accept;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      fill_in = fill_ff + QFILL_BITS'(push) - QFILL_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

>>> hw/rtl/fcbs_back.sv
// Back part: executes queued requests against the stack RAM and drives results.
module fcbs_back import fcbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        q_valid,
   input  item_type    q_item,
   output logic        q_pop,
   fcbs_rsp_if.source  rsp_if
);

   state_type              state_ff, state_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [BLOCK_BITS-1:0]  total_ff, total_in;
   logic                   refill_ff, refill_in;
   logic [CNT_BITS-1:0]    ridx_ff, ridx_in;
   logic [BLOCK_BITS-1:0]  pending_ff, pending_in;
   logic [IDX_BITS-1:0]    ptr_ff, ptr_in;
   logic [IDX_BITS-1:0]    top_ff, top_in;
   logic [IDX_BITS-1:0]    low_ff, low_in;
   kind_type               fin_kind_ff, fin_kind_in;
   logic [BLOCK_BITS-1:0]  fin_block_ff, fin_block_in;
   logic [BLOCK_BITS-1:0]  cur_block_ff, cur_block_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   kind_type               rsp_kind_ff;
   logic [BLOCK_BITS-1:0]  rsp_block_ff;
   logic                   rsp_last_ff;
   logic [CNT_BITS-1:0]    rsp_count_ff;
   logic [BLOCK_BITS-1:0]  rsp_total_ff;

   logic                   out_free;
   logic                   emit;
   kind_type               emit_kind;
   logic [BLOCK_BITS-1:0]  emit_block;
   logic                   emit_last;
   logic                   wr_en;
   logic [IDX_BITS-1:0]    wr_addr;
   logic [BLOCK_BITS-1:0]  wr_data;
   logic [BLOCK_BITS-1:0]  rd_data;
   logic [BLOCK_BITS-1:0]  total_inc;
   logic [BLOCK_BITS-1:0]  total_dec;

   fcbs_ram #(
      .WIDTH(BLOCK_BITS),
      .DEPTH(FREE_SLOTS)
   ) u_stack (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(ptr_in),
      .rd_data(rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign total_inc = (total_ff == '1) ? total_ff : total_ff + 1'b1;
   assign total_dec = (total_ff == '0) ? total_ff : total_ff - 1'b1;

   // An allocate scans down the stack first, so that every skipped-entry result can
   // carry the final counts, and then reads the skipped entries again to report them.
   always_comb begin
      logic has_bad;
      has_bad = 1'b0;
      state_in = state_ff;
      count_in = count_ff;
      total_in = total_ff;
      refill_in = refill_ff;
      ridx_in = ridx_ff;
      pending_in = pending_ff;
      ptr_in = ptr_ff;
      top_in = top_ff;
      low_in = low_ff;
      fin_kind_in = fin_kind_ff;
      fin_block_in = fin_block_ff;
      cur_block_in = cur_block_ff;
      q_pop = 1'b0;
      emit = 1'b0;
      emit_kind = KIND_ALLOC;
      emit_block = '0;
      emit_last = 1'b1;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               unique case (q_item.cmd)
                  CMD_ALLOC: begin
                     if (refill_ff) begin
                        emit = 1'b1;
                        emit_kind = KIND_NO_SPACE;
                     end else if (count_ff == '0 || count_ff > CNT_BITS'(FREE_SLOTS)) begin
                        count_in = '0;
                        total_in = '0;
                        ridx_in = '0;
                        emit = 1'b1;
                        emit_kind = KIND_NO_SPACE;
                     end else begin
                        top_in = IDX_BITS'(count_ff - 1'b1);
                        ptr_in = IDX_BITS'(count_ff - 1'b1);
                        state_in = ST_SCAN;
                     end
                  end
                  CMD_FREE: begin
                     if (refill_ff || !q_item.in_range) begin
                        emit = 1'b1;
                        emit_kind = KIND_BAD_BLOCK;
                        emit_block = q_item.block;
                     end else if (count_ff == '0) begin
                        wr_en = 1'b1;
                        wr_addr = '0;
                        wr_data = '0;
                        count_in = CNT_BITS'(1);
                        cur_block_in = q_item.block;
                        state_in = ST_PUSH;
                     end else if (count_ff >= CNT_BITS'(FREE_SLOTS)) begin
                        emit = 1'b1;
                        emit_kind = KIND_SPILL_WORD;
                        emit_block = BLOCK_BITS'(count_ff);
                        emit_last = 1'b0;
                        count_in = CNT_BITS'(1);
                        total_in = total_inc;
                        cur_block_in = q_item.block;
                        ptr_in = '0;
                        state_in = ST_SPILL;
                     end else begin
                        wr_en = 1'b1;
                        wr_addr = count_ff[IDX_BITS-1:0];
                        wr_data = q_item.block;
                        count_in = count_ff + 1'b1;
                        total_in = total_inc;
                        emit = 1'b1;
                        emit_kind = KIND_FREED;
                        emit_block = q_item.block;
                     end
                  end
                  CMD_REFILL: begin
                     if (!refill_ff) begin
                        emit = 1'b0;
                     end else if (ridx_ff == '0) begin
                        if (q_item.read_error || q_item.block == '0 ||
                            q_item.block > BLOCK_BITS'(FREE_SLOTS)) begin
                           count_in = '0;
                           total_in = '0;
                           refill_in = 1'b0;
                           ridx_in = '0;
                           emit = 1'b1;
                           emit_kind = KIND_NO_SPACE;
                        end else begin
                           count_in = CNT_BITS'(q_item.block);
                           ridx_in = CNT_BITS'(1);
                        end
                     end else begin
                        wr_en = 1'b1;
                        wr_addr = IDX_BITS'(ridx_ff - 1'b1);
                        wr_data = q_item.block;
                        ridx_in = ridx_ff + 1'b1;
                        if (ridx_ff >= count_ff) begin
                           refill_in = 1'b0;
                           ridx_in = '0;
                           total_in = total_dec;
                           emit = 1'b1;
                           emit_kind = KIND_ALLOC;
                           emit_block = pending_ff;
                        end
                     end
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_PUSH: begin
            if (out_free) begin
               wr_en = 1'b1;
               wr_addr = count_ff[IDX_BITS-1:0];
               wr_data = cur_block_ff;
               count_in = count_ff + 1'b1;
               total_in = total_inc;
               emit = 1'b1;
               emit_kind = KIND_FREED;
               emit_block = cur_block_ff;
               state_in = ST_IDLE;
            end
         end
         ST_SPILL: begin
            if (out_free) begin
               emit = 1'b1;
               emit_kind = KIND_SPILL_WORD;
               emit_block = rd_data;
               emit_last = 1'b0;
               if (ptr_ff == IDX_BITS'(FREE_SLOTS - 1)) begin
                  state_in = ST_SPILL_PUSH;
               end else begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end
         end
         ST_SPILL_PUSH: begin
            if (out_free) begin
               wr_en = 1'b1;
               wr_addr = '0;
               wr_data = cur_block_ff;
               emit = 1'b1;
               emit_kind = KIND_FREED;
               emit_block = cur_block_ff;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (rd_data == '0) begin
               count_in = '0;
               total_in = '0;
               ridx_in = '0;
               fin_kind_in = KIND_NO_SPACE;
               fin_block_in = '0;
               has_bad = (ptr_ff != top_ff);
               low_in = ptr_ff + 1'b1;
               state_in = ST_FINAL;
            end else if (block_in_range(rd_data, cfg)) begin
               fin_block_in = rd_data;
               if (ptr_ff == '0) begin
                  fin_kind_in = KIND_READ_REQUEST;
                  count_in = '0;
                  refill_in = 1'b1;
                  ridx_in = '0;
                  pending_in = rd_data;
               end else begin
                  fin_kind_in = KIND_ALLOC;
                  count_in = CNT_BITS'(ptr_ff);
                  total_in = total_dec;
               end
               has_bad = (ptr_ff != top_ff);
               low_in = ptr_ff + 1'b1;
               state_in = ST_FINAL;
            end else if (ptr_ff == '0) begin
               count_in = '0;
               total_in = '0;
               ridx_in = '0;
               fin_kind_in = KIND_NO_SPACE;
               fin_block_in = '0;
               has_bad = 1'b1;
               low_in = '0;
               state_in = ST_FINAL;
            end else begin
               ptr_in = ptr_ff - 1'b1;
            end
            if (has_bad) begin
               ptr_in = top_ff;
               state_in = ST_BAD;
            end
         end
         ST_BAD: begin
            if (out_free) begin
               emit = 1'b1;
               emit_kind = KIND_BAD_BLOCK;
               emit_block = rd_data;
               emit_last = 1'b0;
               if (ptr_ff == low_ff) begin
                  state_in = ST_FINAL;
               end else begin
                  ptr_in = ptr_ff - 1'b1;
               end
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               emit = 1'b1;
               emit_kind = fin_kind_ff;
               emit_block = fin_block_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         total_ff <= '0;
         refill_ff <= 1'b0;
         ridx_ff <= '0;
         pending_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         total_ff <= total_in;
         refill_ff <= refill_in;
         ridx_ff <= ridx_in;
         pending_ff <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      top_ff <= top_in;
      low_ff <= low_in;
      fin_kind_ff <= fin_kind_in;
      fin_block_ff <= fin_block_in;
      cur_block_ff <= cur_block_in;
      if (emit) begin
         rsp_kind_ff <= emit_kind;
         rsp_block_ff <= emit_block;
         rsp_last_ff <= emit_last;
         rsp_count_ff <= count_in;
         rsp_total_ff <= total_in;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.kind = rsp_kind_ff;
   assign rsp_if.block = rsp_block_ff;
   assign rsp_if.last = rsp_last_ff;
   assign rsp_if.cached_count = rsp_count_ff;
   assign rsp_if.total_free = rsp_total_ff;

endmodule

>>> hw/rtl/chained_free_block_stack_unit.sv
// Top level of the chained free block stack with its configuration registers.
//
//   Channel  Direction  Handshake        Carries
//   req_if   in         valid/ready      opcode, block_number, read_error
//   rsp_if   out        valid/ready      kind, block, last, cached_count, total_free
//   csr_if   in         valid/ready=1    index, data
//
// A request passes through the front queue; the back part then handles a free, a refill word
// or a rejected request from its idle state, and a free onto an empty stack via ST_PUSH.
// An allocate scans down the cached entries and then reads each skipped one again, as the
// stack RAM has a single read port.
// A free onto a full stack gives 52 results.
// Reset is synchronous and clears counts, refill state and queues; stack contents are
// left as they are. Results leave through one output register, and the front queue keeps
// taking requests while a result waits, as long as it has room.
module chained_free_block_stack_unit import fcbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   fcbs_req_if.sink    req_if,
   fcbs_rsp_if.source  rsp_if,
   fcbs_csr_if.sink    csr_if
);

   cfg_type   cfg_ff, cfg_in;
   logic      q_valid;
   item_type  q_item;
   logic      q_pop;

   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_FIRST_DATA_BLOCK: cfg_in.first_data_block = csr_if.data;
            CSR_DEVICE_BLOCKS: cfg_in.device_blocks = csr_if.data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_data_block <= FIRST_DATA_BLOCK_RESET;
         cfg_ff.device_blocks <= DEVICE_BLOCKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fcbs_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .cfg    (cfg_ff),
      .q_valid(q_valid),
      .q_item (q_item),
      .q_pop  (q_pop)
   );

   fcbs_back u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .q_valid(q_valid),
      .q_item (q_item),
      .q_pop  (q_pop),
      .rsp_if (rsp_if)
   );

endmodule

>>> hw/rtl/fcbs_checker.sv
// Port-level assertions on the result channel, bound to the top level.
module fcbs_checker import fcbs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [KIND_BITS-1:0]  rsp_kind,
   input  logic [BLOCK_BITS-1:0] rsp_block,
   input  logic                  rsp_last,
   input  logic [CNT_BITS-1:0]   rsp_cached_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_block) && $stable(rsp_last))
      else $error("result changed or dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_freed_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_FREED |-> rsp_last && rsp_cached_count != '0)
      else $error("freed result not last or with an empty stack");

   a_read_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_READ_REQUEST |->
      rsp_last && rsp_cached_count == '0)
      else $error("read request not last or with a nonempty stack");

   a_no_space: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_NO_SPACE |-> rsp_last && rsp_block == '0)
      else $error("no space result not last or with a nonzero block");

endmodule

bind chained_free_block_stack_unit fcbs_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_kind        (rsp_if.kind),
   .rsp_block       (rsp_if.block),
   .rsp_last        (rsp_if.last),
   .rsp_cached_count(rsp_if.cached_count)
);
